@@ rtl/sfr_pkg.sv @@
// shared types, constants and codes of the serial frame receiver
package sfr_pkg;

    localparam int SUM_START_INDEX_DEF = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_TICK = 1'b1;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_OPENED   = 3'd1;
    localparam logic [2:0] EV_STORED   = 3'd2;
    localparam logic [2:0] EV_GOOD     = 3'd3;
    localparam logic [2:0] EV_BAD_SUM  = 3'd4;
    localparam logic [2:0] EV_OVERFLOW = 3'd5;
    localparam logic [2:0] EV_TIMEOUT  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_WAKE_BYTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BYTE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_BIAS = 3'd6;

    localparam logic [7:0] MAX_LEN_CAP = 8'd254;

    typedef struct packed {
        logic [7:0]  wake_byte;
        logic [7:0]  start_byte;
        logic [7:0]  stop_byte;
        logic [7:0]  min_frame_len;
        logic [7:0]  max_frame_len;
        logic [15:0] timeout_ticks;
        logic [7:0]  checksum_bias;
    } cfg_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic       open_hit;
        logic       stop_hit;
    } item_t;

endpackage

@@ rtl/sfr_front.sv @@
// front stage: takes input transfers and classifies the byte against the config
module sfr_front
    import sfr_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       push,
    output item_t      item
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        item.operation = operation;
        item.rx_byte   = rx_byte;
        item.open_hit  = (rx_byte != cfg.wake_byte) && (rx_byte == cfg.start_byte);
        item.stop_hit  = (rx_byte == cfg.stop_byte);
    end

endmodule

@@ rtl/sfr_queue.sv @@
// short fifo between the front and back stages
module sfr_queue
    import sfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  q_valid,
    output logic  q_full,
    output item_t head
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

    item_t           mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == DepthC);
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/sfr_back.sv @@
// back stage: frame state, sum check and the registered result
module sfr_back
    import sfr_pkg::*;
#(
    parameter int SUM_START_INDEX = SUM_START_INDEX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  item_t      head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [7:0] frame_length,
    output logic [7:0] received_checksum,
    output logic [7:0] computed_checksum
);

    localparam logic [7:0] SumFrom = 8'(SUM_START_INDEX + 2);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [7:0]  last_reg;
    logic [7:0]  last_next;
    logic [7:0]  second_reg;
    logic [7:0]  second_next;
    logic [15:0] idle_reg;
    logic [15:0] idle_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [2:0]  ev_reg;
    logic [2:0]  ev_next;
    logic [7:0]  dbyte_reg;
    logic [7:0]  dbyte_next;
    logic [7:0]  idx_reg;
    logic [7:0]  idx_next;
    logic [7:0]  flen_reg;
    logic [7:0]  flen_next;
    logic [7:0]  rcs_reg;
    logic [7:0]  rcs_next;
    logic [7:0]  ccs_reg;
    logic [7:0]  ccs_next;

    logic [15:0] idle_inc;
    logic [7:0]  len;
    logic [7:0]  max_len;
    logic [7:0]  sum_acc;
    logic [7:0]  check;

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        second_next   = second_reg;
        idle_next     = idle_reg;
        ev_next       = EV_NONE;
        dbyte_next    = '0;
        idx_next      = '0;
        flen_next     = '0;
        rcs_next      = '0;
        ccs_next      = '0;
        idle_inc      = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
        len           = count_reg + 8'd1;
        max_len       = (cfg.max_frame_len > MAX_LEN_CAP) ? MAX_LEN_CAP : cfg.max_frame_len;
        sum_acc       = (count_reg >= SumFrom) ? sum_reg + second_reg : sum_reg;
        check         = sum_acc - cfg.checksum_bias;

        if (head.operation == OP_TICK)
        begin
            idle_next = idle_inc;
            if (in_frame_reg && (idle_inc > cfg.timeout_ticks))
            begin
                ev_next       = EV_TIMEOUT;
                flen_next     = count_reg;
                in_frame_next = 1'b0;
                count_next    = '0;
                sum_next      = '0;
                last_next     = '0;
                second_next   = '0;
            end
        end
        else
        begin
            idle_next = '0;
            if (!in_frame_reg)
            begin
                if (head.open_hit)
                begin
                    in_frame_next = 1'b1;
                    count_next    = 8'd1;
                    sum_next      = '0;
                    last_next     = head.rx_byte;
                    second_next   = '0;
                    ev_next       = EV_OPENED;
                    dbyte_next    = head.rx_byte;
                    flen_next     = 8'd1;
                end
            end
            else
            begin
                dbyte_next = head.rx_byte;
                idx_next   = count_reg;
                flen_next  = len;
                if (head.stop_hit && (len >= cfg.min_frame_len))
                begin
                    rcs_next      = last_reg;
                    ccs_next      = check;
                    ev_next       = (check == last_reg) ? EV_GOOD : EV_BAD_SUM;
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    sum_next      = '0;
                    last_next     = '0;
                    second_next   = '0;
                end
                else if (len > max_len)
                begin
                    ev_next       = EV_OVERFLOW;
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    sum_next      = '0;
                    last_next     = '0;
                    second_next   = '0;
                end
                else
                begin
                    ev_next     = EV_STORED;
                    count_next  = len;
                    sum_next    = sum_acc;
                    second_next = last_reg;
                    last_next   = head.rx_byte;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            last_reg      <= '0;
            second_reg    <= '0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                in_frame_reg <= in_frame_next;
                count_reg    <= count_next;
                sum_reg      <= sum_next;
                last_reg     <= last_next;
                second_reg   <= second_next;
                idle_reg     <= idle_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg    <= ev_next;
            dbyte_reg <= dbyte_next;
            idx_reg   <= idx_next;
            flen_reg  <= flen_next;
            rcs_reg   <= rcs_next;
            ccs_reg   <= ccs_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign event_res         = ev_reg;
    assign data_byte         = dbyte_reg;
    assign byte_index        = idx_reg;
    assign frame_length      = flen_reg;
    assign received_checksum = rcs_reg;
    assign computed_checksum = ccs_reg;

`ifndef SYNTHESIS
    a_idle_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (count_reg == '0) && (sum_reg == '0) && (last_reg == '0))
        else $error("frame state not cleared outside a frame");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (count_reg != '0) && (count_reg <= MAX_LEN_CAP))
        else $error("frame count out of range");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (ev_next == EV_GOOD || ev_next == EV_BAD_SUM || ev_next == EV_OVERFLOW
            || ev_next == EV_TIMEOUT) |=> !in_frame_reg && out_valid_reg)
        else $error("frame still open after close");

    a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (head.operation == OP_BYTE) |=> (idle_reg == '0))
        else $error("idle count not cleared by a byte");
`endif

endmodule

@@ rtl/serial_frame_receiver_with_sum_check_unit.sv @@
// top level: config registers, front classifier, queue and back stage
// Deframes a byte stream into frames opened by the start byte and closed by the stop
// byte, reporting one result per transfer: opened, stored, good or bad checksum,
// overflow discard, timeout flush, or nothing. A transfer is taken every cycle unless the
// queue is full; its result passes through the queue and the result register, and the
// back stage takes one item per clock while the output is not stalled. A two-entry queue
// between the classifier and the back stage lets new input be taken while a result waits.
// Config writes are always ready and should be made only while the block is idle.
module serial_frame_receiver_with_sum_check_unit
    import sfr_pkg::*;
#(
    parameter int SUM_START_INDEX = SUM_START_INDEX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            event_res,
    output logic [7:0]            data_byte,
    output logic [7:0]            byte_index,
    output logic [7:0]            frame_length,
    output logic [7:0]            received_checksum,
    output logic [7:0]            computed_checksum,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push;
    logic  pop;
    logic  q_valid;
    logic  q_full;
    item_t push_item;
    item_t head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WAKE_BYTE:     cfg_next.wake_byte     = cfg_data[7:0];
                REG_START_BYTE:    cfg_next.start_byte    = cfg_data[7:0];
                REG_STOP_BYTE:     cfg_next.stop_byte     = cfg_data[7:0];
                REG_MIN_FRAME_LEN: cfg_next.min_frame_len = cfg_data[7:0];
                REG_MAX_FRAME_LEN: cfg_next.max_frame_len = cfg_data[7:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[15:0];
                REG_CHECKSUM_BIAS: cfg_next.checksum_bias = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wake_byte     <= 8'd254;
            cfg_reg.start_byte    <= 8'h68;
            cfg_reg.stop_byte     <= 8'd22;
            cfg_reg.min_frame_len <= 8'd22;
            cfg_reg.max_frame_len <= 8'd200;
            cfg_reg.timeout_ticks <= 16'd50;
            cfg_reg.checksum_bias <= 8'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sfr_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .item      (push_item)
    );

    sfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .head      (head)
    );

    sfr_back #(
        .SUM_START_INDEX (SUM_START_INDEX)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .q_valid           (q_valid),
        .head              (head),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_res         (event_res),
        .data_byte         (data_byte),
        .byte_index        (byte_index),
        .frame_length      (frame_length),
        .received_checksum (received_checksum),
        .computed_checksum (computed_checksum)
    );

endmodule

@@ sim/testbench.sv @@
// testbench for the serial frame receiver: deframing, sum check and flush against a local model
`timescale 1ns / 100ps

module testbench;
    import sfr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 60;
    localparam int SUM_FROM = SUM_START_INDEX_DEF;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] data;
        logic [7:0] idx;
        logic [7:0] flen;
        logic [7:0] rcs;
        logic [7:0] ccs;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = OP_BYTE;
    logic [7:0]            rx_byte = 8'd0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            event_res;
    logic [7:0]            data_byte;
    logic [7:0]            byte_index;
    logic [7:0]            frame_length;
    logic [7:0]            received_checksum;
    logic [7:0]            computed_checksum;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WAKE_BYTE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    serial_frame_receiver_with_sum_check_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_res         (event_res),
        .data_byte         (data_byte),
        .byte_index        (byte_index),
        .frame_length      (frame_length),
        .received_checksum (received_checksum),
        .computed_checksum (computed_checksum),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    // local copy of registers and frame state
    cfg_t        model_cfg;
    logic        in_frm;
    logic [7:0]  frm_cnt;
    logic [7:0]  run_sum;
    logic [7:0]  last_b;
    logic [7:0]  prev_b;
    logic [15:0] idle_cnt;

    frame_result_t pending_results[$];
    int mismatches = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    function automatic void clear_frame_state();
        in_frm = 1'b0;
        frm_cnt = 8'd0;
        run_sum = 8'd0;
        last_b = 8'd0;
        prev_b = 8'd0;
    endfunction

    function automatic int max_len_eff();
        return (model_cfg.max_frame_len > MAX_LEN_CAP) ? MAX_LEN_CAP : model_cfg.max_frame_len;
    endfunction

    function automatic frame_result_t deframe_step(input logic op, input logic [7:0] b);
        frame_result_t res;
        int pos;
        int len;
        logic [7:0] csum;
        res = '0;
        if (op == OP_TICK) begin
            if (idle_cnt != 16'hFFFF)
                idle_cnt = idle_cnt + 16'd1;
            if (in_frm && idle_cnt > model_cfg.timeout_ticks) begin
                res.ev = EV_TIMEOUT;
                res.flen = frm_cnt;
                clear_frame_state();
            end
        end
        else begin
            idle_cnt = 16'd0;
            if (!in_frm) begin
                if (b != model_cfg.wake_byte && b == model_cfg.start_byte) begin
                    clear_frame_state();
                    in_frm = 1'b1;
                    frm_cnt = 8'd1;
                    last_b = b;
                    res.ev = EV_OPENED;
                    res.data = b;
                    res.flen = 8'd1;
                end
            end
            else begin
                pos = frm_cnt;
                len = pos + 1;
                if (pos >= SUM_FROM + 2)
                    run_sum = run_sum + prev_b;
                res.data = b;
                res.idx = pos[7:0];
                res.flen = len[7:0];
                if (b == model_cfg.stop_byte && len >= model_cfg.min_frame_len) begin
                    csum = run_sum - model_cfg.checksum_bias;
                    res.rcs = last_b;
                    res.ccs = csum;
                    res.ev = (csum == last_b) ? EV_GOOD : EV_BAD_SUM;
                    clear_frame_state();
                end
                else if (len > max_len_eff()) begin
                    res.ev = EV_OVERFLOW;
                    clear_frame_state();
                end
                else begin
                    res.ev = EV_STORED;
                    frm_cnt = len[7:0];
                    prev_b = last_b;
                    last_b = b;
                end
            end
        end
        return res;
    endfunction

    // mostly short idles, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk) begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, event", event_res, EV_NONE);
            end
            else begin
                want = pending_results.pop_front();
                if (event_res !== want.ev)
                    report_mismatch("event_res", event_res, want.ev);
                if (data_byte !== want.data)
                    report_mismatch("data_byte", data_byte, want.data);
                if (byte_index !== want.idx)
                    report_mismatch("byte_index", byte_index, want.idx);
                if (frame_length !== want.flen)
                    report_mismatch("frame_length", frame_length, want.flen);
                if (received_checksum !== want.rcs)
                    report_mismatch("received_checksum", received_checksum, want.rcs);
                if (computed_checksum !== want.ccs)
                    report_mismatch("computed_checksum", computed_checksum, want.ccs);
            end
        end
    end

    // receiver stalls, with a long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end
            else begin
                out_stall = 1'b0;
                if (!quiet && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap() + 1;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("serial_frame_receiver_with_sum_check_unit test failed");
            $finish;
        end
    end

    // all tasks but report_mismatch start and return at a falling edge
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        operation = op;
        rx_byte = b;
        forever begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_results.insert(pending_results.size(), deframe_step(op, b));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_WAKE_BYTE:     model_cfg.wake_byte = value[7:0];
            REG_START_BYTE:    model_cfg.start_byte = value[7:0];
            REG_STOP_BYTE:     model_cfg.stop_byte = value[7:0];
            REG_MIN_FRAME_LEN: model_cfg.min_frame_len = value[7:0];
            REG_MAX_FRAME_LEN: model_cfg.max_frame_len = value[7:0];
            REG_TIMEOUT_TICKS: model_cfg.timeout_ticks = value;
            REG_CHECKSUM_BIAS: model_cfg.checksum_bias = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] wake, input logic [7:0] start,
                              input logic [7:0] stop, input logic [7:0] minl,
                              input logic [7:0] maxl, input logic [15:0] tmo,
                              input logic [7:0] bias);
        drain();
        write_reg(REG_WAKE_BYTE, {8'd0, wake});
        write_reg(REG_START_BYTE, {8'd0, start});
        write_reg(REG_STOP_BYTE, {8'd0, stop});
        write_reg(REG_MIN_FRAME_LEN, {8'd0, minl});
        write_reg(REG_MAX_FRAME_LEN, {8'd0, maxl});
        write_reg(REG_TIMEOUT_TICKS, tmo);
        write_reg(REG_CHECKSUM_BIAS, {8'd0, bias});
    endtask

    // start byte, body, then optionally checksum and stop byte
    task automatic send_frame(input int n_body, input bit with_stop, input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'd0;
        send_item(OP_BYTE, model_cfg.start_byte);
        for (int i = 1; i <= n_body; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_TICK, 8'($urandom_range(0, 255)));
            if (with_stop && i == n_body) begin
                b = good_sum ? 8'(sum - model_cfg.checksum_bias) : 8'($urandom_range(0, 255));
            end
            else begin
                b = 8'($urandom_range(0, 255));
                while (b == model_cfg.stop_byte && $urandom_range(0, 19) != 0)
                    b = 8'($urandom_range(0, 255));
                if (i >= SUM_FROM)
                    sum = sum + b;
            end
            send_item(OP_BYTE, b);
        end
        if (with_stop)
            send_item(OP_BYTE, model_cfg.stop_byte);
    endtask

    task automatic run_traffic(input int n);
        int target;
        int r;
        int n_body;
        target = items_sent + n;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else if (r < 15) begin
                repeat ($urandom_range(1, 3)) send_item(OP_BYTE, model_cfg.wake_byte);
            end
            else if (r < 22 && max_len_eff() <= 64) begin
                send_frame(max_len_eff(), 1'b0, 1'b0);
            end
            else if (r < 30 && model_cfg.timeout_ticks <= 40) begin
                send_frame($urandom_range(0, 5), 1'b0, 1'b0);
                repeat (model_cfg.timeout_ticks + 1)
                    send_item(OP_TICK, 8'($urandom_range(0, 255)));
            end
            else begin
                n_body = (model_cfg.min_frame_len > 3) ? model_cfg.min_frame_len - 2 : 1;
                n_body = n_body + $urandom_range(0, 4);
                if (n_body > 253)
                    n_body = 253;
                send_frame(n_body, 1'b1, $urandom_range(0, 99) < 70);
            end
        end
    endtask

    task automatic test_directed_cases();
        send_item(OP_BYTE, 8'd254);
        send_item(OP_BYTE, 8'd0);
        send_item(OP_BYTE, 8'd255);
        send_item(OP_TICK, 8'd0);
        set_config(8'd254, 8'h68, 8'd22, 8'd2, 8'd12, 16'd1, 8'd2);
        // two-byte frame: checksum is the start byte
        send_item(OP_BYTE, 8'h68);
        send_item(OP_BYTE, 8'd22);
        send_item(OP_BYTE, 8'h68);
        send_item(OP_BYTE, 8'hFE);
        send_item(OP_BYTE, 8'd22);
        // flush after idle ticks
        send_item(OP_BYTE, 8'h68);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_TICK, 8'h00);
        // stop before min length is stored, min above max overflows
        drain();
        write_reg(REG_MIN_FRAME_LEN, 16'd20);
        send_item(OP_BYTE, 8'h68);
        repeat (12) send_item(OP_BYTE, 8'd22);
    endtask

    task automatic test_default_config();
        set_config(8'd254, 8'd104, 8'd22, 8'd22, 8'd200, 16'd50, 8'd2);
        run_traffic(200);
    endtask

    task automatic test_extreme_values();
        set_config(8'd0, 8'd255, 8'd0, 8'd10, 8'd10, 16'hFFFF, 8'd0);
        quiet = 1'b1;
        run_traffic(100);
        quiet = 1'b0;
        set_config(8'd255, 8'd0, 8'd255, 8'd10, 8'd254, 16'd1, 8'd255);
        run_traffic(100);
    endtask

    task automatic test_long_frames();
        set_config(8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 16'hFFFF, 8'd255);
        send_frame(253, 1'b1, 1'b1);
        send_frame(254, 1'b0, 1'b0);
    endtask

    task automatic test_backpressure();
        set_config(8'd254, 8'h68, 8'd22, 8'd10, 8'd30, 16'd5, 8'd2);
        quiet = 1'b1;
        hold_req = 1'b1;
        run_traffic(80);
        quiet = 1'b0;
    endtask

    task automatic test_random_configs();
        repeat (2) begin
            set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(10, 40)),
                       8'($urandom_range(10, 60)), 16'($urandom_range(1, 20)),
                       8'($urandom_range(0, 255)));
            run_traffic(130);
        end
    endtask

    task automatic test_start_equals_wake();
        set_config(8'h68, 8'h68, 8'd22, 8'd10, 8'd20, 16'd5, 8'd2);
        run_traffic(40);
    endtask

    initial begin
        model_cfg.wake_byte = 8'd254;
        model_cfg.start_byte = 8'd104;
        model_cfg.stop_byte = 8'd22;
        model_cfg.min_frame_len = 8'd22;
        model_cfg.max_frame_len = 8'd200;
        model_cfg.timeout_ticks = 16'd50;
        model_cfg.checksum_bias = 8'd2;
        clear_frame_state();
        idle_cnt = 16'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_default_config();
        test_extreme_values();
        test_long_frames();
        test_backpressure();
        test_random_configs();
        test_start_equals_wake();
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("serial_frame_receiver_with_sum_check_unit test passed");
        else
            $display("serial_frame_receiver_with_sum_check_unit test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/serial_frame_receiver_with_sum_check_unit.sv
sim/testbench.sv
